>>> design/kgr_pkg.sv
// Shared widths and the control bundle for the k-group reversal buffer.
package kgr_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic load;  // shift one place away from the input, cell 0 takes the new value
    logic pop;   // shift one place toward the input, cell 0 takes its right neighbor
  } cell_ctrl_t;

endpackage

>>> design/kgr_cell.sv
// One storage cell of the group chain: holds one value and trades it with its neighbors.
module kgr_cell (
  input  logic               clk,
  input  kgr_pkg::cell_ctrl_t ctrl,
  input  kgr_pkg::data_t     from_left,
  input  kgr_pkg::data_t     from_right,
  output kgr_pkg::data_t     value
);

  kgr_pkg::data_t stored;

  // load and pop are never raised together
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      stored <= from_left;
    end else if (ctrl.pop) begin
      stored <= from_right;
    end
  end

  assign value = stored;

endmodule

>>> design/k_group_reversal_buffer.sv
// Top level of the k-group reversal buffer: cell chain, emit sequencer and output register.
//
// The block collects signed 32-bit values into groups of group_size and sends each full
// group out newest first; a group cut short by tlast comes out oldest first, and a size of
// 0 or 1 passes values straight through (sizes above MAX_GROUP act as MAX_GROUP). Each
// accepted value enters a row of MAX_GROUP cells, which shift on every load. When a
// group closes, input is held off while the row drains into the output register, one
// value per cycle while the downstream side does not stall; a new value is taken only
// once the group has gone out to the output register. Reversed groups are popped from
// cell 0 as the row shifts back toward the input; forward groups are read from the
// oldest held cell. m_tlast marks the last result of one group, m_tuser the end of the
// sequence. group_size may be written only while the block is idle.
module k_group_reversal_buffer #(
  parameter int MAX_GROUP = 16
) (
  input  logic        clk,
  input  logic        rst,

  // configuration write channel: group_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [kgr_pkg::CFG_W-1:0] cfg_data,   // [4:0] group_size

  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,                  // [31:0] item_value
  input  logic        s_tlast,                  // seq_end

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,                  // [31:0] out_value
  output logic        m_tlast,                  // run_last
  output logic        m_tuser                   // out_seq_end
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int IDX_W = $clog2(MAX_GROUP);
  localparam int CMP_W = (CNT_W > kgr_pkg::CFG_W) ? CNT_W : kgr_pkg::CFG_W;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic                     state;
  logic [CNT_W-1:0]         cnt;
  logic [kgr_pkg::CFG_W-1:0] group_size;
  logic                     rev;
  logic                     seq;

  kgr_pkg::data_t           cell_val [MAX_GROUP];
  kgr_pkg::cell_ctrl_t      ctrl;

  logic [CMP_W-1:0]         size_w;
  logic [CMP_W-1:0]         k_eff;
  logic [CMP_W-1:0]         cnt_inc;
  logic                     full;
  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         rd_idx;
  logic                     accept_in;
  logic                     out_free;
  logic                     emit_go;
  kgr_pkg::data_t           emit_val;

  // Config: always ready; to be written only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= kgr_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      group_size <= cfg_data;
    end
  end

  // Effective group size: saturate at MAX_GROUP, treat 0 as 1
  always_comb begin
    size_w = CMP_W'(group_size);
    if (size_w > CMP_W'(MAX_GROUP)) begin
      k_eff = CMP_W'(MAX_GROUP);
    end else if (size_w == '0) begin
      k_eff = CMP_W'(1);
    end else begin
      k_eff = size_w;
    end
  end

  assign cnt_inc   = CMP_W'(cnt) + CMP_W'(1);
  assign full      = (cnt_inc >= k_eff);
  assign s_tready  = (state == ST_COLLECT);
  assign accept_in = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit_go   = (state == ST_EMIT) && out_free;

  // Forward order reads the oldest held value, which sits at cell cnt-1
  assign cnt_m1   = cnt - CNT_W'(1);
  assign rd_idx   = cnt_m1[IDX_W-1:0];
  assign emit_val = rev ? cell_val[0] : cell_val[rd_idx];

  assign ctrl.load = accept_in;
  assign ctrl.pop  = emit_go && rev;

  // Cell row: cell 0 faces the input, cell MAX_GROUP-1 the far end
  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    kgr_pkg::data_t left_in;
    kgr_pkg::data_t right_in;

    if (i == 0) begin : g_head
      assign left_in = kgr_pkg::data_t'(s_tdata);
    end else begin : g_body
      assign left_in = cell_val[i-1];
    end

    if (i == MAX_GROUP - 1) begin : g_tail
      assign right_in = cell_val[i];
    end else begin : g_inner
      assign right_in = cell_val[i+1];
    end

    kgr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_left  (left_in),
      .from_right (right_in),
      .value      (cell_val[i])
    );
  end

  // Sequencer: collect until the group closes, then drain one value per cycle while the output is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept_in) begin
            cnt <= cnt_inc[CNT_W-1:0];
            if (full || s_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            cnt      <= cnt_m1;
            if (cnt == CNT_W'(1)) begin
              state <= ST_COLLECT;
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // Group mode and output payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept_in) begin
      rev <= full && (k_eff >= CMP_W'(2));
      seq <= s_tlast;
    end
    if (emit_go) begin
      m_tdata <= emit_val;
      m_tlast <= (cnt == CNT_W'(1));
      m_tuser <= (cnt == CNT_W'(1)) && seq;
    end
  end

  // Fill count never passes the row length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_GROUP))
    else $error("fill count beyond cell row");

  // While collecting there is always a free cell for the next value
  a_collect_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLLECT) |-> (cnt < CNT_W'(MAX_GROUP)))
    else $error("cell row full while collecting");

  // Draining never runs on an empty row
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (cnt != '0))
    else $error("emit with no held values");

  // The final emit of a group closes the run and returns to collecting
  a_emit_close: assert property (@(posedge clk) disable iff (rst)
    (emit_go && (cnt == CNT_W'(1))) |=> (state == ST_COLLECT) && m_tvalid && m_tlast)
    else $error("group drain did not close its run");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the k-group reversal buffer: directed group shapes plus random streams.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_GROUP    = 16;
  localparam int DRAIN_CYCLES = 48;   // covers a full group emit plus the output register
  localparam int RANDOM_ITEMS = 380;

  typedef struct {
    kgr_pkg::data_t value;
    logic           run_last;
    logic           seq_end;
  } out_beat_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [kgr_pkg::CFG_W-1:0] cfg_data;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [31:0]               s_tdata;
  logic                      s_tlast;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [31:0]               m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;

  // Mirror of the block: held group, fill count and the group_size register.
  kgr_pkg::data_t            held_vals [MAX_GROUP];
  int                        held_cnt = 0;
  logic [kgr_pkg::CFG_W-1:0] size_reg = kgr_pkg::CFG_W'(1);
  out_beat_t                 expected_beats [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int error_count    = 0;
  bit sizes_written [32];

  k_group_reversal_buffer #(
    .MAX_GROUP(MAX_GROUP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Stall the result side at the current pressure; change only at the falling edge.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Store one value and queue whatever it releases: a full group newest first,
  // a group closed by the end of sequence oldest first, single values in pass-through.
  task automatic reorder_model(kgr_pkg::data_t v, logic last);
    int        k;
    int        n;
    bit        rev;
    out_beat_t b;
    k = int'(size_reg);
    if (k > MAX_GROUP) k = MAX_GROUP;
    if (k < 1) k = 1;
    held_vals[held_cnt] = v;
    held_cnt++;
    if (held_cnt >= k) begin
      rev = (k >= 2);
    end else if (last) begin
      rev = 1'b0;
    end else begin
      return;
    end
    n = held_cnt;
    for (int i = 0; i < n; i++) begin
      b.value    = rev ? held_vals[n-1-i] : held_vals[i];
      b.run_last = (i == n - 1);
      b.seq_end  = (i == n - 1) && last;
      expected_beats.push_back(b);
    end
    held_cnt = 0;
  endtask

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Compare every result transaction with the oldest queued expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        note_error($sformatf("%0t: unexpected result value %h last %b seq_end %b",
                             $realtime, m_tdata, m_tlast, m_tuser));
      end else begin
        want = expected_beats.pop_front();
        if (m_tdata !== want.value || m_tlast !== want.run_last ||
            m_tuser !== want.seq_end) begin
          note_error($sformatf(
            "%0t: mismatch: expected value %h last %b seq_end %b, got %h %b %b",
            $realtime, want.value, want.run_last, want.seq_end,
            m_tdata, m_tlast, m_tuser));
        end
      end
    end
  end

  // Offer one value, with random sender gaps, and hold it until accepted.
  task automatic push_value(kgr_pkg::data_t v, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tlast  = 1'($urandom_range(1));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reorder_model(v, last);
    items_sent++;
  endtask

  // Drop valid, drain every expected result, then let the block settle.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write group_size only once the block is idle.
  task automatic write_group_size(int sz);
    wait_quiet();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = kgr_pkg::CFG_W'(sz);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_reg          = kgr_pkg::CFG_W'(sz);
    sizes_written[sz] = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = kgr_pkg::CFG_W'($urandom);
  endtask

  function automatic kgr_pkg::data_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return kgr_pkg::data_t'($urandom_range(15));
      default: return kgr_pkg::data_t'($urandom);
    endcase
  endfunction

  // Favor small groups; still hit pass-through, the maximum and the saturating sizes.
  function automatic int pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return MAX_GROUP;
      3:       return int'($urandom_range(MAX_GROUP + 1, 31));
      default: return int'($urandom_range(2, 8));
    endcase
  endfunction

  // Mostly well-formed sequences ended by tlast; some broken ones with stray tlast
  // or no tlast, and now and then a size change halfway through a sequence.
  task automatic run_random(int send_pct, int recv_pct, int n_items);
    int   sent;
    int   len;
    int   ke;
    int   sz;
    bit   broken;
    logic last;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      sz = pick_size();
      write_group_size(sz);
      ke = (sz > MAX_GROUP) ? MAX_GROUP : ((sz < 1) ? 1 : sz);
      len    = $urandom_range(1, 3 * ke + 1);
      broken = ($urandom_range(9) < 2);
      for (int i = 0; i < len; i++) begin
        if (broken) last = ($urandom_range(7) == 0);
        else        last = (i == len - 1);
        if (i != 0 && i == len / 2 && $urandom_range(6) == 0) write_group_size(pick_size());
        push_value(pick_value(), last);
        sent++;
      end
    end
  endtask

  // Reset leaves group_size at 1, so values pass straight through.
  task automatic test_default_passthrough();
    push_value(32'h7fff_ffff, 1'b0);
    push_value(32'h8000_0000, 1'b1);
  endtask

  // Saturated size filling the whole row at sequence end, full group at sequence end, partial group,
  // and size 0 pass-through.
  task automatic test_group_shapes();
    write_group_size(31);
    for (int i = 0; i < MAX_GROUP; i++) begin
      push_value((i % 2) ? kgr_pkg::data_t'(32'h8000_0000 + i)
                         : kgr_pkg::data_t'(32'h7fff_ffff - i),
                 i == MAX_GROUP - 1);
    end
    write_group_size(3);
    push_value(32'h0000_0001, 1'b0);
    push_value(32'hffff_ffff, 1'b0);
    push_value(32'h0000_0000, 1'b1);
    write_group_size(5);
    push_value(32'h1234_5678, 1'b0);
    push_value(32'h8765_4321, 1'b1);
    write_group_size(0);
    push_value(32'h5a5a_a5a5, 1'b1);
  endtask

  // Held values count toward a smaller size: reversed for 2 or more, in order for 1.
  task automatic test_size_lowered_mid_group();
    write_group_size(8);
    push_value(32'h0000_0011, 1'b0);
    push_value(32'h0000_0022, 1'b0);
    write_group_size(2);
    push_value(32'h0000_0033, 1'b0);
    write_group_size(4);
    push_value(32'hcafe_0001, 1'b0);
    write_group_size(1);
    push_value(32'hcafe_0002, 1'b1);
  endtask

  task automatic test_random_no_idle();
    run_random(0, 0, RANDOM_ITEMS / 4);
  endtask

  task automatic test_random_sender_idle();
    run_random(80, 0, RANDOM_ITEMS / 4);
  endtask

  task automatic test_random_receiver_stall();
    run_random(0, 80, RANDOM_ITEMS / 4);
  endtask

  task automatic test_random_both_idle();
    run_random(33, 33, RANDOM_ITEMS / 4);
  endtask

  initial begin
    int n_sizes;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_passthrough();
    test_group_shapes();
    test_size_lowered_mid_group();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_quiet();

    n_sizes = 0;
    foreach (sizes_written[i]) n_sizes += sizes_written[i];
    $display("run covered %0d input transactions and %0d result transactions,",
             items_sent, results_seen);
    $display("%0d distinct group sizes, four idle/stall mixes, %0d mismatches",
             n_sizes, error_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/kgr_pkg.sv
design/kgr_cell.sv
design/k_group_reversal_buffer.sv
bench/testbench.sv
